// ===== rtl/pba_pkg.sv =====
// Shared constants for the polygon box, area and orientation block.
// No dependencies; the interfaces and the top level refer to it by scoped names.
package pba_pkg;

    // Default vertex coordinate width and vertex count limit.
    localparam int COORD_BITS_DEF = 24;
    localparam int MAX_POINTS_DEF = 1024;

    // Fixed result widths: the area accumulator wraps at 64 bits and is
    // reported clamped to a signed 63-bit value; the count field is 11 bits.
    localparam int ACC_BITS       = 64;
    localparam int AREA_BITS      = 63;
    localparam int COUNT_OUT_BITS = 11;

    // Smallest vertex count that forms a ring with an area and an orientation.
    localparam int MIN_RING = 3;

endpackage

// ===== rtl/pba_if.sv =====
// Valid/ready channel interfaces for vertex items and polygon result items.
// Depends on pba_pkg for default widths.
interface pba_vtx_if #(
    parameter int COORD_BITS = pba_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;

    modport source (output valid, x, y, last, input ready);
    modport sink   (input valid, x, y, last, output ready);
endinterface

interface pba_res_if #(
    parameter int COORD_BITS = pba_pkg::COORD_BITS_DEF
) ();
    logic                                   valid;
    logic                                   ready;
    logic signed [COORD_BITS-1:0]           box_x_min;
    logic signed [COORD_BITS-1:0]           box_y_min;
    logic signed [COORD_BITS-1:0]           box_x_max;
    logic signed [COORD_BITS-1:0]           box_y_max;
    logic signed [pba_pkg::AREA_BITS-1:0]   twice_area;
    logic                                   counter_clockwise;
    logic [pba_pkg::COUNT_OUT_BITS-1:0]     vertex_count;

    modport source (output valid, box_x_min, box_y_min, box_x_max, box_y_max,
                    twice_area, counter_clockwise, vertex_count, input ready);
    modport sink   (input valid, box_x_min, box_y_min, box_x_max, box_y_max,
                    twice_area, counter_clockwise, vertex_count, output ready);
endinterface

// ===== rtl/polygon_box_area_orientation.sv =====
// Top level of the streaming polygon bounding box, area and orientation block.
// Depends on pba_pkg and on the channel interfaces in pba_if.sv.
//
// Usage: vertices enter on i_vtx, one item per vertex, as signed x,y with a
// last flag on the closing vertex. Each polygon yields exactly one item on
// o_res when its last vertex has gone through: the bounding box, twice the
// signed shoelace area over the closed ring (clamped to 63 bits, zero below
// three vertices), the orientation flag taken at the first leftmost vertex
// and the saturating vertex count. Vertices that are not last yield nothing.
// Throughput is one vertex per cycle while the pipeline is not frozen; the
// rate is set by the polygon state update in stage 2, which takes one
// vertex each cycle. A last vertex passes the input register, state
// update, multipliers, accumulator and final area add, and lands in the
// output register, which then raises o_res.valid.
// While a result waits in the output register, vertices keep moving; only
// when the next result reaches the last stage does the pipeline freeze, and
// i_vtx.ready falls in that same cycle, so nothing is lost until the result
// is taken. Synchronous reset empties the pipeline, clears the area
// accumulator and closes any polygon that was open; the next vertex starts a
// new polygon.
module polygon_box_area_orientation #(
    parameter int COORD_BITS = pba_pkg::COORD_BITS_DEF,
    parameter int MAX_POINTS = pba_pkg::MAX_POINTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pba_vtx_if.sink   i_vtx,
    pba_res_if.source o_res
);

    // Coordinate differences and sums need one extra bit; products of two of
    // them fit in PW bits and a difference of two products in XW bits.
    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;
    localparam int AW = pba_pkg::ACC_BITS;
    localparam int OW = pba_pkg::AREA_BITS;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int KW = pba_pkg::COUNT_OUT_BITS;

    typedef struct packed {
        logic signed [C-1:0] x_min;
        logic signed [C-1:0] y_min;
        logic signed [C-1:0] x_max;
        logic signed [C-1:0] y_max;
    } t_box;

    // Per-item facts carried down the pipeline next to the valid bits.
    typedef struct packed {
        logic          last;
        logic          few;
        logic [CW-1:0] cnt;
    } t_tag;

    function automatic logic [DW-1:0] ext(input logic [C-1:0] v);
        return {v[C-1], v};
    endfunction

    function automatic logic [AW-1:0] ext_acc(input logic [PW-1:0] v);
        return {{(AW - PW){v[PW-1]}}, v};
    endfunction

    // The output register loads whenever it is free or being emptied in this
    // cycle. The pipeline advances then, and also whenever the last stage
    // holds no result, since nothing has to enter the output register.
    logic adv;
    logic out_free;
    logic r_out_vld;

    // Stage valid bits: bit 0 is the input register, bit 4 feeds the output.
    logic [4:0] r_vld;

    // Stage 5: closing edge added in.
    logic [AW-1:0]        r_s5_total;
    logic                 r_s5_ccw;
    t_tag                 r_s5_tag;
    t_box                 r_s5_box;

    assign out_free    = !r_out_vld || o_res.ready;
    assign adv         = out_free || !(r_vld[4] && r_s5_tag.last);
    assign i_vtx.ready = adv;

    // Stage 1: input register.
    logic signed [C-1:0] r_s1_x;
    logic signed [C-1:0] r_s1_y;
    logic                r_s1_last;

    // Polygon state, updated in stage 2.
    logic [CW-1:0]       r_count;
    logic                r_succ_pending;
    logic                r_left_is_first;
    logic signed [C-1:0] r_first_x, r_first_y;
    logic signed [C-1:0] r_prev_x, r_prev_y;
    logic signed [C-1:0] r_left_x, r_left_y;
    logic signed [C-1:0] r_pred_x, r_pred_y;
    logic signed [C-1:0] r_succ_x, r_succ_y;
    t_box                r_box;

    // State after this vertex, before a last vertex closes the polygon.
    logic [CW-1:0]       n_count;
    logic                n_succ_pending;
    logic                n_left_is_first;
    logic signed [C-1:0] n_first_x, n_first_y;
    logic signed [C-1:0] n_left_x, n_left_y;
    logic signed [C-1:0] n_pred_x, n_pred_y;
    logic signed [C-1:0] n_succ_x, n_succ_y;
    t_box                n_box;
    logic                poly_open;
    logic                few;

    assign poly_open = (r_count != '0);
    assign n_count   = (r_count < CW'(MAX_POINTS)) ? r_count + CW'(1) : CW'(MAX_POINTS);
    assign few       = (n_count < CW'(pba_pkg::MIN_RING));

    always_comb begin
        n_first_x       = r_first_x;
        n_first_y       = r_first_y;
        n_left_x        = r_left_x;
        n_left_y        = r_left_y;
        n_pred_x        = r_pred_x;
        n_pred_y        = r_pred_y;
        n_succ_x        = r_succ_x;
        n_succ_y        = r_succ_y;
        n_succ_pending  = r_succ_pending;
        n_left_is_first = r_left_is_first;
        n_box           = r_box;
        if (!poly_open) begin
            // The first vertex opens a polygon and is its own box and leftmost.
            n_first_x       = r_s1_x;
            n_first_y       = r_s1_y;
            n_left_x        = r_s1_x;
            n_left_y        = r_s1_y;
            n_pred_x        = '0;
            n_pred_y        = '0;
            n_succ_x        = '0;
            n_succ_y        = '0;
            n_succ_pending  = 1'b1;
            n_left_is_first = 1'b1;
            n_box.x_min     = r_s1_x;
            n_box.x_max     = r_s1_x;
            n_box.y_min     = r_s1_y;
            n_box.y_max     = r_s1_y;
        end else begin
            if (r_s1_x < r_box.x_min) begin
                n_box.x_min = r_s1_x;
            end
            if (r_s1_x > r_box.x_max) begin
                n_box.x_max = r_s1_x;
            end
            if (r_s1_y < r_box.y_min) begin
                n_box.y_min = r_s1_y;
            end
            if (r_s1_y > r_box.y_max) begin
                n_box.y_max = r_s1_y;
            end
            if (r_succ_pending) begin
                n_succ_x       = r_s1_x;
                n_succ_y       = r_s1_y;
                n_succ_pending = 1'b0;
            end
            // A strictly smaller x takes over; on a tie the earlier vertex stays.
            if (r_s1_x < r_left_x) begin
                n_left_x        = r_s1_x;
                n_left_y        = r_s1_y;
                n_pred_x        = r_prev_x;
                n_pred_y        = r_prev_y;
                n_left_is_first = 1'b0;
                n_succ_pending  = 1'b1;
            end
        end
    end

    // Orientation neighbors of the leftmost vertex. When the leftmost vertex
    // is the first one, its predecessor is the last vertex, or the one before
    // it when the ring was closed by repeating the first vertex. A successor
    // not yet seen wraps to the first vertex.
    logic                closed;
    logic signed [C-1:0] ax, ay, cx, cy;
    logic [DW-1:0]       d1, d2, d3, d4;
    logic [DW-1:0]       s1, e1, s2, e2;

    assign closed = (r_s1_x == n_first_x) && (r_s1_y == n_first_y);

    always_comb begin
        if (n_left_is_first) begin
            ax = closed ? r_prev_x : r_s1_x;
            ay = closed ? r_prev_y : r_s1_y;
        end else begin
            ax = n_pred_x;
            ay = n_pred_y;
        end
        if (n_succ_pending) begin
            cx = n_first_x;
            cy = n_first_y;
        end else begin
            cx = n_succ_x;
            cy = n_succ_y;
        end
    end

    assign d1 = ext(n_left_x) - ext(ax);
    assign d2 = ext(cy) - ext(ay);
    assign d3 = ext(n_left_y) - ext(ay);
    assign d4 = ext(cx) - ext(ax);

    // Area terms: the edge from the previous vertex, and on a last vertex the
    // closing edge back to the first one.
    assign s1 = poly_open ? ext(r_s1_y) + ext(r_prev_y) : '0;
    assign e1 = poly_open ? ext(r_s1_x) - ext(r_prev_x) : '0;
    assign s2 = ext(n_first_y) + ext(r_s1_y);
    assign e2 = ext(n_first_x) - ext(r_s1_x);

    // Stage 2 registers.
    logic signed [DW-1:0] r_s2_s1, r_s2_e1, r_s2_s2, r_s2_e2;
    logic signed [DW-1:0] r_s2_d1, r_s2_d2, r_s2_d3, r_s2_d4;
    t_tag                 r_s2_tag;
    t_box                 r_s2_box;

    // Stage 3: products.
    logic signed [PW-1:0] r_s3_p1, r_s3_p2, r_s3_q1, r_s3_q2;
    t_tag                 r_s3_tag;
    t_box                 r_s3_box;

    // Stage 4: running sum and orientation sign.
    logic [AW-1:0]        r_acc;
    logic [AW-1:0]        n_acc;
    logic [XW-1:0]        cross_prod;
    logic [AW-1:0]        r_s4_sum;
    logic signed [PW-1:0] r_s4_p2;
    logic                 r_s4_ccw;
    t_tag                 r_s4_tag;
    t_box                 r_s4_box;

    assign n_acc      = r_acc + ext_acc(r_s3_p1);
    assign cross_prod = {r_s3_q1[PW-1], r_s3_q1} - {r_s3_q2[PW-1], r_s3_q2};

    // Output register.
    t_box                 r_out_box;
    logic signed [OW-1:0] r_out_area;
    logic                 r_out_ccw;
    logic [KW-1:0]        r_out_cnt;

    // Clamp the wrapped 64-bit sum into the signed 63-bit range.
    logic [OW-1:0]        area_sat;
    logic [KW+CW-1:0]     cnt_wide;

    always_comb begin
        case (r_s5_total[AW-1:AW-2])
            2'b01:   area_sat = {1'b0, {(OW - 1){1'b1}}};
            2'b10:   area_sat = {1'b1, {(OW - 1){1'b0}}};
            default: area_sat = r_s5_total[OW-1:0];
        endcase
    end

    assign cnt_wide = {{KW{1'b0}}, r_s5_tag.cnt};

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld           <= '0;
            r_out_vld       <= 1'b0;
            r_count         <= '0;
            r_succ_pending  <= 1'b0;
            r_left_is_first <= 1'b1;
            r_acc           <= '0;
        end else begin
            if (out_free) begin
                r_out_vld <= r_vld[4] && r_s5_tag.last;
            end
            if (adv) begin
                r_vld <= {r_vld[3:0], i_vtx.valid};
                if (r_vld[0]) begin
                    r_count         <= r_s1_last ? '0 : n_count;
                    r_succ_pending  <= r_s1_last ? 1'b0 : n_succ_pending;
                    r_left_is_first <= r_s1_last ? 1'b1 : n_left_is_first;
                end
                if (r_vld[2]) begin
                    r_acc <= r_s3_tag.last ? '0 : n_acc;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_x    <= i_vtx.x;
            r_s1_y    <= i_vtx.y;
            r_s1_last <= i_vtx.last;

            if (r_vld[0]) begin
                r_first_x <= n_first_x;
                r_first_y <= n_first_y;
                r_prev_x  <= r_s1_x;
                r_prev_y  <= r_s1_y;
                r_left_x  <= n_left_x;
                r_left_y  <= n_left_y;
                r_pred_x  <= n_pred_x;
                r_pred_y  <= n_pred_y;
                r_succ_x  <= n_succ_x;
                r_succ_y  <= n_succ_y;
                r_box     <= n_box;
            end

            r_s2_s1       <= s1;
            r_s2_e1       <= e1;
            r_s2_s2       <= s2;
            r_s2_e2       <= e2;
            r_s2_d1       <= d1;
            r_s2_d2       <= d2;
            r_s2_d3       <= d3;
            r_s2_d4       <= d4;
            r_s2_tag.last <= r_s1_last;
            r_s2_tag.few  <= few;
            r_s2_tag.cnt  <= n_count;
            r_s2_box      <= n_box;

            r_s3_p1  <= r_s2_s1 * r_s2_e1;
            r_s3_p2  <= r_s2_s2 * r_s2_e2;
            r_s3_q1  <= r_s2_d1 * r_s2_d2;
            r_s3_q2  <= r_s2_d3 * r_s2_d4;
            r_s3_tag <= r_s2_tag;
            r_s3_box <= r_s2_box;

            r_s4_sum <= n_acc;
            r_s4_p2  <= r_s3_p2;
            // Below three vertices the flag is set; a zero cross product clears it.
            r_s4_ccw <= r_s3_tag.few || (!cross_prod[XW-1] && (cross_prod != '0));
            r_s4_tag <= r_s3_tag;
            r_s4_box <= r_s3_box;

            r_s5_total <= r_s4_sum + ext_acc(r_s4_p2);
            r_s5_ccw   <= r_s4_ccw;
            r_s5_tag   <= r_s4_tag;
            r_s5_box   <= r_s4_box;
        end

        if (out_free) begin
            r_out_box  <= r_s5_box;
            r_out_area <= r_s5_tag.few ? '0 : area_sat;
            r_out_ccw  <= r_s5_ccw;
            r_out_cnt  <= cnt_wide[KW-1:0];
        end
    end

    assign o_res.valid             = r_out_vld;
    assign o_res.box_x_min         = r_out_box.x_min;
    assign o_res.box_y_min         = r_out_box.y_min;
    assign o_res.box_x_max         = r_out_box.x_max;
    assign o_res.box_y_max         = r_out_box.y_max;
    assign o_res.twice_area        = r_out_area;
    assign o_res.counter_clockwise = r_out_ccw;
    assign o_res.vertex_count      = r_out_cnt;

`ifndef NO_ASSERTIONS
    // A last vertex leaving the state stage closes the polygon.
    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_vld[0] && r_s1_last) |=> (r_count == '0))
        else $error("polygon left open after its last vertex");

    // The area accumulator starts from zero for the next polygon.
    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_vld[2] && r_s3_tag.last) |=> (r_acc == '0))
        else $error("area accumulator not cleared after a polygon");

    // A delivered box is never inverted.
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.box_x_min <= o_res.box_x_max)
                         && (o_res.box_y_min <= o_res.box_y_max)))
        else $error("bounding box minimum above maximum");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for polygon_box_area_orientation: streams polygons in, checks results.
// Depends on pba_pkg, on the channel interfaces in pba_if.sv and on the top level RTL.

typedef logic signed [pba_pkg::COORD_BITS_DEF-1:0] t_coord;

typedef struct {
    t_coord                              x_min;
    t_coord                              y_min;
    t_coord                              x_max;
    t_coord                              y_max;
    logic signed [pba_pkg::AREA_BITS-1:0] twice_area;
    logic                                ccw;
    logic [pba_pkg::COUNT_OUT_BITS-1:0]  count;
} t_poly_result;

// Tracks the open polygon the way the block should and holds the results it owes.
class polygon_scoreboard;
    localparam logic signed [63:0] AREA_HI = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] AREA_LO = 64'shC000_0000_0000_0000;

    longint             first_x, first_y, prev_x, prev_y;
    longint             box_x_lo, box_y_lo, box_x_hi, box_y_hi;
    logic signed [63:0] area_acc;
    int                 count;
    longint             left_x, left_y, pred_x, pred_y, succ_x, succ_y;
    bit                 succ_pending, left_is_first;
    t_poly_result       expected_results[$];
    int                 errors;

    function new();
        first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
        box_x_lo = 0; box_y_lo = 0; box_x_hi = 0; box_y_hi = 0;
        area_acc = 0;
        count = 0;
        left_x = 0; left_y = 0; pred_x = 0; pred_y = 0; succ_x = 0; succ_y = 0;
        succ_pending = 0;
        left_is_first = 1;
        errors = 0;
    endfunction

    // Called for every vertex that the block accepts.
    function void add_vertex(t_coord vx, t_coord vy, logic vlast);
        longint             x, y, old_x, old_y, ax, ay, cx, cy, cross_prod;
        int                 n;
        bit                 closed, ccw;
        logic signed [63:0] clamped;
        t_poly_result       r;
        x = vx;
        y = vy;
        old_x = prev_x;
        old_y = prev_y;
        if (count == 0) begin
            first_x = x; first_y = y;
            box_x_lo = x; box_x_hi = x;
            box_y_lo = y; box_y_hi = y;
            area_acc = 0;
            left_x = x; left_y = y;
            pred_x = 0; pred_y = 0; succ_x = 0; succ_y = 0;
            left_is_first = 1;
            succ_pending = 1;
        end else begin
            area_acc += (y + prev_y) * (x - prev_x);
            if (x < box_x_lo) box_x_lo = x;
            if (x > box_x_hi) box_x_hi = x;
            if (y < box_y_lo) box_y_lo = y;
            if (y > box_y_hi) box_y_hi = y;
            if (succ_pending) begin
                succ_x = x; succ_y = y;
                succ_pending = 0;
            end
            // A strictly smaller x moves the leftmost vertex; ties keep the earlier one.
            if (x < left_x) begin
                left_x = x; left_y = y;
                pred_x = prev_x; pred_y = prev_y;
                left_is_first = 0;
                succ_pending = 1;
            end
        end
        prev_x = x;
        prev_y = y;
        n = (count < pba_pkg::MAX_POINTS_DEF) ? count + 1 : pba_pkg::MAX_POINTS_DEF;
        count = n;
        if (!vlast) return;

        // Closing edge back to the first vertex.
        area_acc += (first_y + y) * (first_x - x);

        if (n < pba_pkg::MIN_RING) begin
            ccw = 1;
        end else begin
            // A last vertex that repeats the first is not a ring vertex of its own,
            // so the predecessor of a leading leftmost vertex is the one before it.
            closed = (x == first_x) && (y == first_y);
            if (left_is_first) begin
                ax = closed ? old_x : x;
                ay = closed ? old_y : y;
            end else begin
                ax = pred_x;
                ay = pred_y;
            end
            if (succ_pending) begin
                cx = first_x; cy = first_y;
            end else begin
                cx = succ_x; cy = succ_y;
            end
            cross_prod = (left_x - ax) * (cy - ay) - (left_y - ay) * (cx - ax);
            ccw = cross_prod > 0;
        end

        if (area_acc > AREA_HI) clamped = AREA_HI;
        else if (area_acc < AREA_LO) clamped = AREA_LO;
        else clamped = area_acc;

        r.x_min = t_coord'(box_x_lo);
        r.y_min = t_coord'(box_y_lo);
        r.x_max = t_coord'(box_x_hi);
        r.y_max = t_coord'(box_y_hi);
        r.twice_area = (n < pba_pkg::MIN_RING) ? '0 : clamped[pba_pkg::AREA_BITS-1:0];
        r.ccw = ccw;
        r.count = n[pba_pkg::COUNT_OUT_BITS-1:0];
        expected_results = {expected_results, r};

        count = 0;
        succ_pending = 0;
        left_is_first = 1;
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Called for every result item that leaves the block.
    function void check_result(t_poly_result got);
        t_poly_result want;
        if (expected_results.size() == 0) begin
            $error("result item arrived with no polygon closed");
            errors++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("box_x_min", want.x_min, got.x_min);
        compare_field("box_y_min", want.y_min, got.y_min);
        compare_field("box_x_max", want.x_max, got.x_max);
        compare_field("box_y_max", want.y_max, got.y_max);
        compare_field("twice_area", want.twice_area, got.twice_area);
        compare_field("counter_clockwise", {63'd0, want.ccw}, {63'd0, got.ccw});
        compare_field("vertex_count", {53'd0, want.count}, {53'd0, got.count});
    endfunction

    function void report_leftovers();
        if (expected_results.size() != 0) begin
            $error("%0d result items never arrived", expected_results.size());
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int     CB    = pba_pkg::COORD_BITS_DEF;
    localparam t_coord C_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam t_coord C_MIN = {1'b1, {(CB-1){1'b0}}};

    // Coordinate flavors for generated polygons.
    typedef enum int {COORD_FULL, COORD_TIGHT, COORD_EDGE} t_coord_flavor;
    // Receiver behaviors; each one holds for a random span of cycles.
    typedef enum int {RX_OPEN, RX_COIN, RX_CHOKE} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    pba_vtx_if vtx ();
    pba_res_if res ();

    polygon_box_area_orientation u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vtx   (vtx),
        .o_res   (res)
    );

    polygon_scoreboard sb;
    int                burst_left = 0;
    int                random_items = 0;

    always #4 i_clk = ~i_clk;

    // The receiver alternates between always ready, a coin toss per cycle and
    // long chokes where ready is drawn with a one-in-four chance. Results are rare,
    // so the spans are long enough that every mode sees several of them.
    initial begin
        t_rx_mode mode;
        int       span;
        res.ready <= 1'b0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 2));
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    RX_OPEN:  res.ready <= 1'b1;
                    RX_COIN:  res.ready <= 1'($urandom_range(0, 1));
                    default:  res.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Every accepted result goes straight to the scoreboard. Both valid and
    // ready are read before this edge's updates land, so the sample is stable.
    always @(posedge i_clk) begin
        t_poly_result got;
        if (i_rst_n && res.valid && res.ready) begin
            got.x_min      = res.box_x_min;
            got.y_min      = res.box_y_min;
            got.x_max      = res.box_x_max;
            got.y_max      = res.box_y_max;
            got.twice_area = res.twice_area;
            got.ccw        = res.counter_clockwise;
            got.count      = res.vertex_count;
            sb.check_result(got);
        end
    end

    // Offers one vertex and returns once it has been taken. The sender runs in
    // bursts: when one is used up, valid drops for a random gap (possibly none)
    // and a new burst length is drawn; now and then a burst is very long so
    // that stretches without any idling occur as well.
    task automatic push_vertex(input t_coord px, input t_coord py, input logic plast);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                vtx.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        vtx.valid <= 1'b1;
        vtx.x     <= px;
        vtx.y     <= py;
        vtx.last  <= plast;
        do @(posedge i_clk); while (!vtx.ready);
        sb.add_vertex(px, py, plast);
    endtask

    // Lowers valid and holds off until the block has delivered everything owed.
    task automatic wait_for_results();
        vtx.valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_results.size() != 0);
    endtask

    function automatic t_coord pick_coord(t_coord_flavor flavor);
        case (flavor)
            COORD_FULL:  return t_coord'($urandom);
            COORD_TIGHT: return t_coord'(int'($urandom_range(0, 8)) - 4);
            default: begin
                case ($urandom_range(0, 5))
                    0:       return C_MIN;
                    1:       return C_MAX;
                    2:       return '0;
                    3:       return '1;
                    4:       return C_MIN + t_coord'(1);
                    default: return t_coord'($urandom);
                endcase
            end
        endcase
    endfunction

    // One polygon of nv vertices. With closed set, the last vertex repeats
    // the first one, which the block must leave out of the orientation test.
    task automatic send_polygon(input int nv, input t_coord_flavor flavor,
                                input bit closed);
        t_coord fx, fy, px, py;
        for (int i = 0; i < nv; i++) begin
            px = pick_coord(flavor);
            py = pick_coord(flavor);
            if (i == 0) begin
                fx = px;
                fy = py;
            end
            if (closed && i == nv - 1 && i != 0) begin
                px = fx;
                py = fy;
            end
            push_vertex(px, py, i == nv - 1);
        end
    endtask

    initial begin
        int            nv;
        int            guard;
        t_coord_flavor flavor;
        bit            closed;

        sb = new();
        vtx.valid <= 1'b0;
        vtx.x     <= '0;
        vtx.y     <= '0;
        vtx.last  <= 1'b0;
        i_rst_n   <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n   <= 1'b1;

        // Directed polygons. Single vertices at both corners of the range.
        push_vertex(C_MIN, C_MIN, 1'b1);
        push_vertex(C_MAX, C_MAX, 1'b1);
        // Two vertices: box only, area zero, flag set.
        push_vertex(C_MIN, C_MAX, 1'b0);
        push_vertex(C_MAX, C_MIN, 1'b1);
        // Triangles spanning the whole range, in both winding directions.
        push_vertex(C_MIN, C_MIN, 1'b0);
        push_vertex(C_MAX, C_MIN, 1'b0);
        push_vertex(C_MAX, C_MAX, 1'b1);
        push_vertex(C_MIN, C_MIN, 1'b0);
        push_vertex(C_MAX, C_MAX, 1'b0);
        push_vertex(C_MAX, C_MIN, 1'b1);
        // Ring closed by repeating its first vertex; the leftmost vertex is the first.
        push_vertex(t_coord'(0), t_coord'(0), 1'b0);
        push_vertex(t_coord'(4), t_coord'(0), 1'b0);
        push_vertex(t_coord'(0), t_coord'(4), 1'b0);
        push_vertex(t_coord'(0), t_coord'(0), 1'b1);
        // Collinear vertices give a zero cross product and a cleared flag.
        push_vertex(t_coord'(0), t_coord'(0), 1'b0);
        push_vertex(t_coord'(1), t_coord'(1), 1'b0);
        push_vertex(t_coord'(2), t_coord'(2), 1'b1);
        // Leftmost vertex in the middle of the stream, successor seen later.
        push_vertex(t_coord'(5), t_coord'(0), 1'b0);
        push_vertex(t_coord'(5), t_coord'(5), 1'b0);
        push_vertex(t_coord'(-1), t_coord'(2), 1'b0);
        push_vertex(t_coord'(3), t_coord'(1), 1'b1);
        // Leftmost vertex is the last one, so its successor wraps to the first.
        push_vertex(t_coord'(3), t_coord'(0), 1'b0);
        push_vertex(t_coord'(4), t_coord'(4), 1'b0);
        push_vertex(t_coord'(-2), t_coord'(1), 1'b1);

        // Let the pipeline drain completely once before the random traffic.
        wait_for_results();

        // Random polygons, mostly short, in all coordinate flavors. The tight
        // flavor brings ties on the leftmost x, collinear and repeated points.
        while (random_items < 870) begin
            nv = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                             : $urandom_range(1, 10);
            flavor = t_coord_flavor'($urandom_range(0, 2));
            closed = (nv >= 2) && ($urandom_range(0, 4) == 0);
            send_polygon(nv, flavor, closed);
            random_items += nv;
        end

        vtx.valid <= 1'b0;
        guard = 0;
        while (sb.expected_results.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        sb.report_leftovers();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Safety net in case the block stops taking vertices or giving results.
    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule

// ===== polygon_box_area_orientation.f =====
rtl/pba_pkg.sv
rtl/pba_if.sv
rtl/polygon_box_area_orientation.sv
bench/testbench.sv
